// ----- rtl/disjoint_set_union_by_size_macros.svh -----
// ---------------------------------------------------------------------------
// disjoint_set_union_by_size assertion macros
// shared concurrent assertion forms, clocked on i_clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef DISJOINT_SET_UNION_BY_SIZE_MACROS_SVH
`define DISJOINT_SET_UNION_BY_SIZE_MACROS_SVH

// same-cycle implication
`define DSU_ASSERT_IMM(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DSU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dsu_pkg.sv -----
// ---------------------------------------------------------------------------
// dsu_pkg
// shared widths and controller/datapath command and status types
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsu_pkg;

    localparam int unsigned ELEM_W = 10;
    localparam int unsigned ROOT_W = 10;
    localparam int unsigned SIZE_W = 11;
    localparam int unsigned STEP_W = 4;

    localparam logic OP_FIND  = 1'b0;
    localparam logic OP_UNITE = 1'b1;

    typedef struct packed {
        logic load;
        logic wrap_step;
        logic sel_b;
        logic par_rd;
        logic par_from_q;
        logic cur_load;
        logic comp_wr;
        logic save_root;
        logic sz_rd;
        logic res_load;
        logic res_merge;
        logic clr_wr;
    } t_cmd;

    typedef struct packed {
        logic wrap_last;
        logic par_is_self;
        logic addr_is_root;
        logic roots_eq;
        logic out_free;
        logic clr_last;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/dsu_if.sv -----
// ---------------------------------------------------------------------------
// dsu_if
// request and response channels with valid/ready handshake
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dsu_req_if;
    import dsu_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [ELEM_W-1:0] elem_a;
    logic [ELEM_W-1:0] elem_b;

    modport source (output valid, output op, output elem_a, output elem_b, input ready);
    modport sink   (input valid, input op, input elem_a, input elem_b, output ready);
endinterface

interface dsu_rsp_if;
    import dsu_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROOT_W-1:0] root;
    logic [SIZE_W-1:0] set_size;

    modport source (output valid, output root, output set_size, input ready);
    modport sink   (input valid, input root, input set_size, output ready);
endinterface

`default_nettype wire

// ----- rtl/dsu_ctrl.sv -----
// ---------------------------------------------------------------------------
// dsu_ctrl
// sequencer for clear pass, index wrap, find with compression and union
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "disjoint_set_union_by_size_macros.svh"

module dsu_ctrl
    import dsu_pkg::*;
#(
    parameter int unsigned NUM_ELEMS = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic i_op,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    localparam bit NEED_WRAP = (NUM_ELEMS < (2 ** ELEM_W));

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRAP,
        S_FIND_RD,
        S_FIND_CHK,
        S_COMP_START,
        S_COMP,
        S_SIZE_RD,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_op, n_op;
    logic   r_sel_b, n_sel_b;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_sel_b = r_sel_b;
        o_cmd   = '0;
        o_cmd.sel_b = r_sel_b;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_op       = i_op;
                    n_sel_b    = 1'b0;
                    n_state    = NEED_WRAP ? S_WRAP : S_FIND_RD;
                end
            end
            S_WRAP: begin
                o_cmd.wrap_step = 1'b1;
                if (i_sts.wrap_last) begin
                    n_state = S_FIND_RD;
                end
            end
            S_FIND_RD: begin
                o_cmd.par_rd   = 1'b1;
                o_cmd.cur_load = 1'b1;
                n_state        = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                if (i_sts.par_is_self) begin
                    n_state = S_COMP_START;
                end else begin
                    o_cmd.par_rd     = 1'b1;
                    o_cmd.par_from_q = 1'b1;
                    o_cmd.cur_load   = 1'b1;
                end
            end
            S_COMP_START, S_COMP: begin
                o_cmd.par_rd     = 1'b1;
                o_cmd.comp_wr    = 1'b1;
                o_cmd.par_from_q = (r_state == S_COMP);
                if (i_sts.addr_is_root) begin
                    o_cmd.save_root = 1'b1;
                    if (r_op == OP_UNITE && !r_sel_b) begin
                        n_sel_b = 1'b1;
                        n_state = S_FIND_RD;
                    end else begin
                        n_state = S_SIZE_RD;
                    end
                end else begin
                    n_state = S_COMP;
                end
            end
            S_SIZE_RD: begin
                o_cmd.sz_rd = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_merge = (r_op == OP_UNITE) && !i_sts.roots_eq;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_op    <= OP_FIND;
            r_sel_b <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_sel_b <= n_sel_b;
        end
    end

    `DSU_ASSERT_NXT(a_accept_blocks, w_accept, !o_in_ready, "item accepted while busy")
    `DSU_ASSERT_NXT(a_done_frees, (r_state == S_DONE) && i_sts.out_free, o_in_ready,
        "input not reopened after result")

endmodule

`default_nettype wire

// ----- rtl/dsu_dp.sv -----
// ---------------------------------------------------------------------------
// dsu_dp
// parent and size memories, index wrap, root compare and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "disjoint_set_union_by_size_macros.svh"

module dsu_dp
    import dsu_pkg::*;
#(
    parameter int unsigned NUM_ELEMS = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic [ELEM_W-1:0] i_elem_a,
    input  wire logic [ELEM_W-1:0] i_elem_b,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [ROOT_W-1:0]      o_root,
    output logic [SIZE_W-1:0]      o_set_size
);

    localparam int unsigned IW     = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1;
    localparam int unsigned SW     = $clog2(NUM_ELEMS + 1);
    localparam int unsigned DIV_W  = 2 * ELEM_W;
    localparam int unsigned RCP_W  = 2 * ELEM_W;
    localparam int unsigned PROD_W = ELEM_W + RCP_W;
    localparam logic [DIV_W-1:0] NUM_D    = DIV_W'(NUM_ELEMS);
    localparam logic [RCP_W-1:0] RCP      = RCP_W'((2 ** RCP_W + NUM_ELEMS - 1) / NUM_ELEMS);
    localparam logic [IW-1:0]    LAST_IDX = IW'(NUM_ELEMS - 1);

    logic [IW-1:0] parent_mem [NUM_ELEMS];
    logic [SW-1:0] size_mem   [NUM_ELEMS];

    logic [ELEM_W-1:0] r_wa, r_wb;
    logic [ELEM_W-1:0] r_qa, r_qb;
    logic [STEP_W-1:0] r_step;
    logic [IW-1:0]     r_cur, r_ra, r_rb, r_par_q, r_clr;
    logic [SW-1:0]     r_sza_q, r_szb_q;
    logic              r_out_valid;
    logic [ROOT_W-1:0] r_out_root;
    logic [SIZE_W-1:0] r_out_size;

    logic [DIV_W-1:0]  w_ext_a, w_ext_b, w_ma, w_mb;
    logic [PROD_W-1:0] w_pa, w_pb;
    logic [IW-1:0]     w_opnd, w_addr, w_win, w_lose;
    logic [SW-1:0]     w_sum;
    logic              w_comp_we, w_merge_we;
    logic              w_par_we, w_sz_we;
    logic [IW-1:0]     w_par_waddr, w_par_wdata, w_sz_waddr;
    logic [SW-1:0]     w_sz_wdata;

    assign w_ext_a = DIV_W'(r_wa);
    assign w_ext_b = DIV_W'(r_wb);

    // reciprocal multiply for the quotient, then the remainder in the next wrap step
    assign w_pa = PROD_W'(r_wa) * PROD_W'(RCP);
    assign w_pb = PROD_W'(r_wb) * PROD_W'(RCP);
    assign w_ma = DIV_W'(r_qa) * NUM_D;
    assign w_mb = DIV_W'(r_qb) * NUM_D;

    assign w_opnd = i_cmd.sel_b ? IW'(r_wb) : IW'(r_wa);
    assign w_addr = i_cmd.par_from_q ? r_par_q : w_opnd;

    assign w_win  = (r_sza_q < r_szb_q) ? r_rb : r_ra;
    assign w_lose = (r_sza_q < r_szb_q) ? r_ra : r_rb;
    assign w_sum  = r_sza_q + r_szb_q;

    assign w_comp_we  = i_cmd.comp_wr && (w_addr != r_cur);
    assign w_merge_we = i_cmd.res_load && i_cmd.res_merge;

    always_comb begin
        w_par_we    = 1'b0;
        w_par_waddr = r_clr;
        w_par_wdata = r_clr;
        w_sz_we     = 1'b0;
        w_sz_waddr  = r_clr;
        w_sz_wdata  = SW'(1);
        if (i_cmd.clr_wr) begin
            w_par_we = 1'b1;
            w_sz_we  = 1'b1;
        end else if (w_comp_we) begin
            w_par_we    = 1'b1;
            w_par_waddr = w_addr;
            w_par_wdata = r_cur;
        end else if (w_merge_we) begin
            w_par_we    = 1'b1;
            w_par_waddr = w_lose;
            w_par_wdata = w_win;
            w_sz_we     = 1'b1;
            w_sz_waddr  = w_win;
            w_sz_wdata  = w_sum;
        end
    end

    // read-first: a compression write and its read share one address
    always_ff @(posedge i_clk) begin
        if (i_cmd.par_rd) begin
            r_par_q <= parent_mem[w_addr];
        end
        if (w_par_we) begin
            parent_mem[w_par_waddr] <= w_par_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sz_rd) begin
            r_sza_q <= size_mem[r_ra];
            r_szb_q <= size_mem[r_rb];
        end
        if (w_sz_we) begin
            size_mem[w_sz_waddr] <= w_sz_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wa   <= i_elem_a;
            r_wb   <= i_elem_b;
            r_step <= STEP_W'(1);
        end else if (i_cmd.wrap_step) begin
            if (r_step != '0) begin
                r_qa <= w_pa[PROD_W-1:RCP_W];
                r_qb <= w_pb[PROD_W-1:RCP_W];
            end else begin
                r_wa <= ELEM_W'(w_ext_a - w_ma);
                r_wb <= ELEM_W'(w_ext_b - w_mb);
            end
            r_step <= r_step - STEP_W'(1);
        end
        if (i_cmd.cur_load) begin
            r_cur <= w_addr;
        end
        if (i_cmd.save_root) begin
            if (i_cmd.sel_b) begin
                r_rb <= r_cur;
            end else begin
                r_ra <= r_cur;
                r_rb <= r_cur;
            end
        end
        if (i_cmd.res_load) begin
            if (i_cmd.res_merge) begin
                r_out_root <= ROOT_W'(w_win);
                r_out_size <= SIZE_W'(w_sum);
            end else begin
                r_out_root <= ROOT_W'(r_ra);
                r_out_size <= SIZE_W'(r_sza_q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.wrap_last    = (r_step == '0);
    assign o_sts.par_is_self  = (r_par_q == r_cur);
    assign o_sts.addr_is_root = (w_addr == r_cur);
    assign o_sts.roots_eq     = (r_ra == r_rb);
    assign o_sts.out_free     = !r_out_valid || i_out_ready;
    assign o_sts.clr_last     = (r_clr == LAST_IDX);

    assign o_out_valid = r_out_valid;
    assign o_root      = r_out_root;
    assign o_set_size  = r_out_size;

    `DSU_ASSERT_IMM(a_opnd_in_range, i_cmd.par_rd && !i_cmd.par_from_q,
        (DIV_W'(w_opnd) < NUM_D) && (w_ext_a < NUM_D) && (w_ext_b < NUM_D),
        "operand index not wrapped")
    `DSU_ASSERT_IMM(a_no_overwrite, i_cmd.res_load, !r_out_valid || i_out_ready,
        "result loaded over a pending one")
    `DSU_ASSERT_NXT(a_load_shows, i_cmd.res_load, r_out_valid, "loaded result not shown")
    `DSU_ASSERT_IMM(a_merge_distinct, w_merge_we, r_ra != r_rb, "merge of a root with itself")

endmodule

`default_nettype wire

// ----- rtl/disjoint_set_union_by_size.sv -----
// ---------------------------------------------------------------------------
// disjoint_set_union_by_size
// union-find table with union by size and full path compression
// ---------------------------------------------------------------------------
// After reset the block sweeps its parent and size memories once, one entry
// per cycle, and takes no item until the sweep is done. One item is worked at
// a time over a single-port parent memory with registered reads. A find walks
// a path link by link to reach the root, then walks it again to point each
// link at the root; a unite runs two finds. Every item then reads the sizes
// and loads the result, and an index wrap comes first when NUM_ELEMS is below
// 1024. The result sits in an output register, so the next item is taken
// while it waits.
`timescale 1ns / 1ps
`default_nettype none

module disjoint_set_union_by_size
    import dsu_pkg::*;
#(
    parameter int unsigned NUM_ELEMS = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dsu_req_if.sink    i_req,
    dsu_rsp_if.source  o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;

    dsu_ctrl #(
        .NUM_ELEMS (NUM_ELEMS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_op       (i_req.op),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    dsu_dp #(
        .NUM_ELEMS (NUM_ELEMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_elem_a    (i_req.elem_a),
        .i_elem_b    (i_req.elem_b),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_root      (o_rsp.root),
        .o_set_size  (o_rsp.set_size)
    );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// union-find table check: a local forest model with path compression
// predicts root and set size for every accepted item. Stimulus runs a
// directed part, then windowed random unite/find traffic to grow trees of
// varied depth, then a spanning merge of all elements into one set. Both
// channels idle in phases, and the response side holds off once for a long
// stretch so that the block fills up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import dsu_pkg::*;

    localparam int NUM_ELEMS   = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_AT     = 600;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 64;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic              op;
        logic [ELEM_W-1:0] elem_a;
        logic [ELEM_W-1:0] elem_b;
    } t_uf_req;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [SIZE_W-1:0] set_size;
    } t_set_info;

    logic i_clk;
    logic i_rst_n;

    dsu_req_if req_if ();
    dsu_rsp_if rsp_if ();

    disjoint_set_union_by_size #(
        .NUM_ELEMS (NUM_ELEMS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_uf_req           op_queue[$];
    t_set_info         set_info_queue[$];
    logic [ELEM_W-1:0] uf_parent[NUM_ELEMS];
    logic [SIZE_W-1:0] uf_size[NUM_ELEMS];

    int         items_accepted = 0;
    int         results_checked = 0;
    int         mismatch_cnt = 0;
    int         offer_mark = -1;
    int         hold_left = 0;
    bit         hold_done = 0;
    int         cycle_cnt = 0;
    t_idle_mode idle_mode;

    assign idle_mode = t_idle_mode'((items_accepted / PHASE_ITEMS) % 4);

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // forest model: walk to the root, then point the whole path at it
    function automatic logic [ELEM_W-1:0] find_root(logic [ELEM_W-1:0] e);
        logic [ELEM_W-1:0] r;
        logic [ELEM_W-1:0] cur;
        logic [ELEM_W-1:0] nxt;
        r = e;
        while (uf_parent[r] != r) r = uf_parent[r];
        cur = e;
        while (cur != r) begin
            nxt = uf_parent[cur];
            uf_parent[cur] = r;
            cur = nxt;
        end
        return r;
    endfunction

    function automatic t_set_info apply_set_op(t_uf_req rq);
        logic [ELEM_W-1:0] ra;
        logic [ELEM_W-1:0] rb;
        logic [ELEM_W-1:0] t;
        t_set_info         info;
        ra = find_root(rq.elem_a);
        if (rq.op == OP_UNITE) begin
            rb = find_root(rq.elem_b);
            if (ra != rb) begin
                // smaller set goes under the larger, ties keep elem_a's root
                if (uf_size[ra] < uf_size[rb]) begin
                    t  = ra;
                    ra = rb;
                    rb = t;
                end
                uf_parent[rb] = ra;
                uf_size[ra]   = uf_size[ra] + uf_size[rb];
            end
        end
        info.root     = ra;
        info.set_size = uf_size[ra];
        return info;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s at result %0d: got %0d expected %0d",
                 what, results_checked, got, want);
        mismatch_cnt++;
    endtask

    task automatic push_item(logic op, logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
        t_uf_req rq;
        rq.op     = op;
        rq.elem_a = a;
        rq.elem_b = b;
        op_queue.insert(op_queue.size(), rq);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && items_accepted == offer_mark) begin
            // item still waiting for ready
        end else if (op_queue.size() > 0 &&
                     !((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 81) ||
                       (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 34))) begin
            req_if.valid  <= 1'b1;
            req_if.op     <= op_queue[0].op;
            req_if.elem_a <= op_queue[0].elem_a;
            req_if.elem_b <= op_queue[0].elem_b;
            offer_mark = items_accepted;
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // accepted items feed the model
    always @(posedge i_clk) begin
        t_uf_req rq;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            rq.op     = req_if.op;
            rq.elem_a = req_if.elem_a;
            rq.elem_b = req_if.elem_b;
            set_info_queue.insert(set_info_queue.size(), apply_set_op(rq));
            void'(op_queue.pop_front());
            items_accepted++;
        end
    end

    // long hold-off on the response side
    always @(posedge i_clk) begin
        if (!hold_done && items_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_left > 0) begin
            rsp_if.ready <= 1'b0;
        end else if (idle_mode == IDLE_RECEIVER) begin
            rsp_if.ready <= $urandom_range(0, 99) >= 81;
        end else if (idle_mode == IDLE_BOTH) begin
            rsp_if.ready <= $urandom_range(0, 99) >= 34;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        t_set_info want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (set_info_queue.size() == 0) begin
                report_mismatch("result with no item pending", rsp_if.root, -1);
            end else begin
                want = set_info_queue.pop_front();
                if (rsp_if.root !== want.root)
                    report_mismatch("root", rsp_if.root, want.root);
                if (rsp_if.set_size !== want.set_size)
                    report_mismatch("set_size", rsp_if.set_size, want.set_size);
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int perm[NUM_ELEMS];
        int base;
        int span;
        int run_len;
        int j;
        int t;
        int random_items;

        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.op     = OP_FIND;
        req_if.elem_a = '0;
        req_if.elem_b = '0;
        rsp_if.ready  = 1'b0;

        for (int i = 0; i < NUM_ELEMS; i++) begin
            uf_parent[i] = ELEM_W'(i);
            uf_size[i]   = SIZE_W'(1);
        end

        // directed: extremes, ties, same-set unite, ignored elem_b, deep paths
        push_item(OP_FIND,  10'd0,    10'd0);
        push_item(OP_FIND,  10'd1023, 10'd1023);
        push_item(OP_UNITE, 10'd0,    10'd0);
        push_item(OP_UNITE, 10'd1,    10'd2);
        push_item(OP_UNITE, 10'd3,    10'd1);
        push_item(OP_UNITE, 10'd4,    10'd5);
        push_item(OP_UNITE, 10'd4,    10'd1);
        push_item(OP_UNITE, 10'd6,    10'd7);
        push_item(OP_UNITE, 10'd8,    10'd9);
        push_item(OP_UNITE, 10'd6,    10'd8);
        push_item(OP_UNITE, 10'd2,    10'd9);
        push_item(OP_FIND,  10'd9,    10'd1023);
        push_item(OP_FIND,  10'd7,    10'd512);
        push_item(OP_UNITE, 10'd3,    10'd5);
        push_item(OP_UNITE, 10'd1023, 10'd1022);
        push_item(OP_UNITE, 10'd512,  10'd1023);
        push_item(OP_UNITE, 10'd1022, 10'd0);
        push_item(OP_FIND,  10'd512,  10'd341);
        push_item(OP_UNITE, 10'd682,  10'd341);
        push_item(OP_UNITE, 10'd9,    10'd682);
        push_item(OP_FIND,  10'd1022, 10'd0);

        // windowed random traffic so sets collide and trees deepen
        random_items = 0;
        while (random_items < 620) begin
            base    = $urandom_range(0, NUM_ELEMS - 1);
            span    = 8 << $urandom_range(0, 4);
            run_len = $urandom_range(20, 60);
            for (int k = 0; k < run_len; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_item(1'($urandom_range(0, 1)),
                              ELEM_W'($urandom_range(0, NUM_ELEMS - 1)),
                              ELEM_W'($urandom_range(0, NUM_ELEMS - 1)));
                end else begin
                    push_item($urandom_range(0, 9) < 7 ? OP_UNITE : OP_FIND,
                              ELEM_W'(base + $urandom_range(0, span - 1)),
                              ELEM_W'(base + $urandom_range(0, span - 1)));
                end
                random_items++;
            end
        end

        // spanning merge in random order: everything ends in one set
        for (int i = 0; i < NUM_ELEMS; i++) perm[i] = i;
        for (int i = NUM_ELEMS - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 1; i < NUM_ELEMS; i++) begin
            j = $urandom_range(0, i - 1);
            if ($urandom_range(0, 1) == 0)
                push_item(OP_UNITE, ELEM_W'(perm[i]), ELEM_W'(perm[j]));
            else
                push_item(OP_UNITE, ELEM_W'(perm[j]), ELEM_W'(perm[i]));
            if ($urandom_range(0, 9) == 0)
                push_item(OP_FIND, ELEM_W'(perm[$urandom_range(0, i)]),
                          ELEM_W'($urandom_range(0, NUM_ELEMS - 1)));
        end
        push_item(OP_FIND,  10'd0,    10'd1023);
        push_item(OP_FIND,  10'd1023, 10'd0);
        push_item(OP_UNITE, 10'd511,  10'd512);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() != 0 || set_info_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
